// ===== hdl/event_interest_table_ready_queue_macros.svh =====
// Assertion helpers used by the top-level file to check block behavior.
`ifndef EVENT_INTEREST_TABLE_READY_QUEUE_MACROS_SVH
`define EVENT_INTEREST_TABLE_READY_QUEUE_MACROS_SVH

// The consequence must hold in the same cycle as the condition.
`define EITRQ_ASSERT_NOW(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("event table check failed in the same cycle");

// The consequence must hold in the cycle after the condition.
`define EITRQ_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("event table check failed in the next cycle");

`endif

// ===== hdl/eitrq_pkg.sv =====
`default_nettype none
package eitrq_pkg;

    typedef enum logic [2:0] {
        KIND_CREATE = 3'd0,
        KIND_CLOSE  = 3'd1,
        KIND_ADD    = 3'd2,
        KIND_MODIFY = 3'd3,
        KIND_DELETE = 3'd4,
        KIND_NOTIFY = 3'd5,
        KIND_CLEAR  = 3'd6,
        KIND_WAIT   = 3'd7
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_ERR   = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // A wait never returns more items than this.
    localparam int RESULT_CAP = 16;
    localparam int CAP_W      = 5;

    localparam logic [31:0] EDGE_MASK_RESET = 32'h8000_0000;

    localparam int IN_W   = 160;
    localparam int OUT_W  = 104;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    latch;
        logic    create;
        logic    close;
        logic    inst_req;
        logic    inst_zero;
        logic    inst_inc;
        logic    scan_start;
        logic    scan_read;
        logic    scan_check;
        logic    add;
        logic    modify;
        logic    remove;
        logic    notify;
        logic    clear_rdy;
        logic    ring_read;
        logic    emit;
        logic    emit_pop;
        status_t emit_status;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        kind_t kind;
        logic  req_ok;
        logic  any_free;
        logic  batch_ok;
        logic  ring_empty;
        logic  hit;
        logic  scan_last;
        logic  found;
        logic  free_found;
        logic  inst_active;
        logic  inst_last;
        logic  out_free;
        logic  pop_last;
    } stat_t;

endpackage
`default_nettype wire

// ===== hdl/eitrq_ram.sv =====
`default_nettype none
module eitrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== hdl/eitrq_ctrl.sv =====
`default_nettype none
module eitrq_ctrl
    import eitrq_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_tvalid,
    output logic       s_tready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_APPLY,
        S_INST_CHK,
        S_INST_NEXT,
        S_RESP,
        S_WAIT_RD,
        S_WAIT_EMIT
    } state_t;

    state_t  state_reg, state_next;
    status_t resp_reg, resp_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        cmd        = '0;
        cmd.emit_status = ST_OK;
        state_next = state_reg;
        resp_next  = resp_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.latch  = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                state_next = S_RESP;
                resp_next  = ST_ERR;
                case (stat.kind)
                    KIND_CREATE: begin
                        if (stat.any_free) begin
                            cmd.create = 1'b1;
                            resp_next  = ST_OK;
                        end
                    end
                    KIND_CLOSE: begin
                        if (stat.req_ok) begin
                            cmd.close = 1'b1;
                            resp_next = ST_OK;
                        end
                    end
                    KIND_ADD, KIND_MODIFY, KIND_DELETE: begin
                        if (stat.req_ok) begin
                            cmd.inst_req   = 1'b1;
                            cmd.scan_start = 1'b1;
                            state_next     = S_SCAN_RD;
                        end
                    end
                    KIND_NOTIFY, KIND_CLEAR: begin
                        cmd.inst_zero = 1'b1;
                        state_next    = S_INST_CHK;
                    end
                    KIND_WAIT: begin
                        if (stat.req_ok && stat.batch_ok) begin
                            if (stat.ring_empty) begin
                                resp_next = ST_EMPTY;
                            end else begin
                                cmd.ring_read = 1'b1;
                                state_next    = S_WAIT_EMIT;
                            end
                        end
                    end
                    default: begin
                        state_next = S_RESP;
                    end
                endcase
            end
            S_SCAN_RD: begin
                cmd.scan_read = 1'b1;
                state_next    = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                cmd.scan_check = 1'b1;
                if (stat.hit || stat.scan_last) begin
                    state_next = S_APPLY;
                end else begin
                    state_next = S_SCAN_RD;
                end
            end
            S_APPLY: begin
                state_next = S_RESP;
                resp_next  = ST_ERR;
                case (stat.kind)
                    KIND_ADD: begin
                        if (!stat.found && stat.free_found) begin
                            cmd.add   = 1'b1;
                            resp_next = ST_OK;
                        end
                    end
                    KIND_MODIFY: begin
                        if (stat.found) begin
                            cmd.modify = 1'b1;
                            resp_next  = ST_OK;
                        end
                    end
                    KIND_DELETE: begin
                        if (stat.found) begin
                            cmd.remove = 1'b1;
                            resp_next  = ST_OK;
                        end
                    end
                    KIND_NOTIFY: begin
                        cmd.notify = stat.found;
                        state_next = S_INST_NEXT;
                    end
                    KIND_CLEAR: begin
                        cmd.clear_rdy = stat.found;
                        state_next    = S_INST_NEXT;
                    end
                    default: begin
                        state_next = S_RESP;
                    end
                endcase
            end
            S_INST_CHK: begin
                if (stat.inst_active) begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN_RD;
                end else begin
                    state_next = S_INST_NEXT;
                end
            end
            S_INST_NEXT: begin
                if (stat.inst_last) begin
                    resp_next  = ST_OK;
                    state_next = S_RESP;
                end else begin
                    cmd.inst_inc = 1'b1;
                    state_next   = S_INST_CHK;
                end
            end
            S_RESP: begin
                if (stat.out_free) begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = resp_reg;
                    state_next      = S_IDLE;
                end
            end
            S_WAIT_RD: begin
                cmd.ring_read = 1'b1;
                state_next    = S_WAIT_EMIT;
            end
            S_WAIT_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit_pop = 1'b1;
                    state_next   = stat.pop_last ? S_IDLE : S_WAIT_RD;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            resp_reg  <= ST_OK;
        end else begin
            state_reg <= state_next;
            resp_reg  <= resp_next;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/eitrq_dp.sv =====
`default_nettype none
module eitrq_dp
    import eitrq_pkg::*;
#(
    parameter int INSTANCES  = 4,
    parameter int SLOTS      = 16,
    parameter int RING_DEPTH = 16,
    parameter int MAX_BATCH  = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [31:0]       cfg_wr_data,
    input  wire logic [IN_W-1:0]   s_tdata,
    input  wire logic [2:0]        s_tuser,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [OUT_W-1:0]       m_tdata,
    output logic [1:0]             m_tuser,
    output logic                   m_tlast,
    input  wire cmd_t              cmd,
    output stat_t                  stat
);

    localparam int IW  = (INSTANCES > 1) ? $clog2(INSTANCES) : 1;
    localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PW  = $clog2(RING_DEPTH);
    localparam int NS  = INSTANCES * SLOTS;
    localparam int NR  = INSTANCES * RING_DEPTH;
    localparam int SAW = (NS > 1) ? $clog2(NS) : 1;
    localparam int RAW = $clog2(NR);
    localparam int SDW = 16 + 32 + 64;
    localparam int RDW = 32 + 64;

    // Latched command item.
    kind_t       kind_reg;
    logic [3:0]  req_reg;
    logic [15:0] fd_reg;
    logic [31:0] interest_reg;
    logic [63:0] udata_reg;
    logic [31:0] evbits_reg;
    logic [7:0]  maxev_reg;

    logic [31:0]    edge_mask_reg;
    logic [INSTANCES-1:0] active_reg;
    logic [NS-1:0]  used_reg;
    logic [NS-1:0]  ready_reg;
    logic [PW-1:0]  head_reg [INSTANCES];
    logic [PW-1:0]  tail_reg [INSTANCES];

    logic [IW-1:0]  cur_reg;
    logic [SW-1:0]  slot_reg;
    logic           found_reg;
    logic           free_reg;
    logic [SAW-1:0] found_addr_reg;
    logic [SAW-1:0] free_addr_reg;
    logic [IW-1:0]  created_reg;
    logic [CAP_W-1:0] pop_cnt_reg;

    logic           out_valid_reg;
    status_t        out_status_reg;
    logic [3:0]     out_idx_reg;
    logic [31:0]    out_ev_reg;
    logic [63:0]    out_data_reg;
    logic           out_last_reg;

    logic [SDW-1:0] slot_rd;
    logic [RDW-1:0] ring_rd;

    logic [IW-1:0]  req_idx;
    logic           req_ok;
    logic [IW-1:0]  free_inst;
    logic           any_free;
    logic [SAW-1:0] scan_addr;
    logic           hit;
    logic [PW-1:0]  head_cur, tail_cur, head_req, tail_req;
    logic [PW-1:0]  tail_wrap, head_wrap;
    logic [CAP_W-1:0] lim;
    logic           pop_last;
    logic [31:0]    matched;
    logic           push_ok;
    logic           slot_we;
    logic [SAW-1:0] slot_waddr;
    logic [RAW-1:0] ring_waddr, ring_raddr;

    assign req_idx = req_reg[IW-1:0];

    always_comb begin
        req_ok = 1'b0;
        for (int n = 0; n < INSTANCES; n++) begin
            if (32'(req_reg) == n) begin
                req_ok = active_reg[n];
            end
        end
    end

    // Lowest inactive instance.
    always_comb begin
        any_free  = 1'b0;
        free_inst = '0;
        for (int n = INSTANCES - 1; n >= 0; n--) begin
            if (!active_reg[n]) begin
                any_free  = 1'b1;
                free_inst = IW'(n);
            end
        end
    end

    assign scan_addr = SAW'(int'(cur_reg) * SLOTS + int'(slot_reg));
    assign hit       = used_reg[scan_addr] && (slot_rd[SDW-1 -: 16] == fd_reg);

    assign head_cur  = head_reg[cur_reg];
    assign tail_cur  = tail_reg[cur_reg];
    assign head_req  = head_reg[req_idx];
    assign tail_req  = tail_reg[req_idx];
    assign tail_wrap = (tail_cur == PW'(RING_DEPTH - 1)) ? '0 : tail_cur + 1'b1;
    assign head_wrap = (head_req == PW'(RING_DEPTH - 1)) ? '0 : head_req + 1'b1;

    assign lim      = (maxev_reg < 8'(RESULT_CAP)) ? CAP_W'(maxev_reg) : CAP_W'(RESULT_CAP);
    assign pop_last = (pop_cnt_reg + 1'b1 == lim) || (head_wrap == tail_req);

    assign matched = evbits_reg & slot_rd[95:64] & ~edge_mask_reg;
    assign push_ok = (tail_wrap != head_cur);

    assign slot_we    = cmd.add || cmd.modify;
    assign slot_waddr = cmd.add ? free_addr_reg : found_addr_reg;
    assign ring_waddr = RAW'(int'(cur_reg) * RING_DEPTH + int'(tail_cur));
    assign ring_raddr = RAW'(int'(req_idx) * RING_DEPTH + int'(head_req));

    eitrq_ram #(.WIDTH(SDW), .DEPTH(NS)) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (slot_we),
        .wr_addr (slot_waddr),
        .wr_data ({fd_reg, interest_reg, udata_reg}),
        .rd_en   (cmd.scan_read),
        .rd_addr (scan_addr),
        .rd_data (slot_rd)
    );

    eitrq_ram #(.WIDTH(RDW), .DEPTH(NR)) u_ring_ram (
        .aclk    (aclk),
        .wr_en   (cmd.notify && matched != '0 && !ready_reg[found_addr_reg] && push_ok),
        .wr_addr (ring_waddr),
        .wr_data ({matched, slot_rd[63:0]}),
        .rd_en   (cmd.ring_read),
        .rd_addr (ring_raddr),
        .rd_data (ring_rd)
    );

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            kind_reg     <= kind_t'(s_tuser);
            req_reg      <= s_tdata[3:0];
            fd_reg       <= s_tdata[19:4];
            interest_reg <= s_tdata[51:20];
            udata_reg    <= s_tdata[115:52];
            evbits_reg   <= s_tdata[147:116];
            maxev_reg    <= s_tdata[155:148];
        end
        if (cmd.create) begin
            created_reg <= free_inst;
        end
        if (cmd.inst_req) begin
            cur_reg <= req_idx;
        end else if (cmd.inst_zero) begin
            cur_reg <= '0;
        end else if (cmd.inst_inc) begin
            cur_reg <= cur_reg + 1'b1;
        end
        if (cmd.scan_check) begin
            if (hit) begin
                found_addr_reg <= scan_addr;
            end
            if (!used_reg[scan_addr] && !free_reg) begin
                free_addr_reg <= scan_addr;
            end
        end
        if (cmd.emit) begin
            out_status_reg <= cmd.emit_status;
            out_idx_reg    <= (kind_reg == KIND_CREATE && cmd.emit_status == ST_OK)
                              ? 4'(created_reg) : 4'd0;
            out_ev_reg     <= '0;
            out_data_reg   <= '0;
            out_last_reg   <= 1'b1;
        end else if (cmd.emit_pop) begin
            out_status_reg <= ST_OK;
            out_idx_reg    <= 4'd0;
            out_ev_reg     <= ring_rd[RDW-1 -: 32];
            out_data_reg   <= ring_rd[63:0];
            out_last_reg   <= pop_last;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            edge_mask_reg <= EDGE_MASK_RESET;
            active_reg    <= '0;
            used_reg      <= '0;
            ready_reg     <= '0;
            slot_reg      <= '0;
            found_reg     <= 1'b0;
            free_reg      <= 1'b0;
            pop_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int n = 0; n < INSTANCES; n++) begin
                head_reg[n] <= '0;
                tail_reg[n] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                edge_mask_reg <= cfg_wr_data;
            end
            if (cmd.latch) begin
                pop_cnt_reg <= '0;
            end
            if (cmd.create || cmd.close) begin
                // An instance starts and ends with an empty table and ring.
                for (int i = 0; i < NS; i++) begin
                    if ((i / SLOTS) == int'(cmd.create ? free_inst : req_idx)) begin
                        used_reg[i]  <= 1'b0;
                        ready_reg[i] <= 1'b0;
                    end
                end
                for (int n = 0; n < INSTANCES; n++) begin
                    if (n == int'(cmd.create ? free_inst : req_idx)) begin
                        head_reg[n]   <= '0;
                        tail_reg[n]   <= '0;
                        active_reg[n] <= cmd.create;
                    end
                end
            end
            if (cmd.scan_start) begin
                slot_reg  <= '0;
                found_reg <= 1'b0;
                free_reg  <= 1'b0;
            end else if (cmd.scan_check) begin
                if (hit) begin
                    found_reg <= 1'b1;
                end else begin
                    slot_reg <= slot_reg + 1'b1;
                end
                if (!used_reg[scan_addr]) begin
                    free_reg <= 1'b1;
                end
            end
            if (cmd.add) begin
                used_reg[free_addr_reg]  <= 1'b1;
                ready_reg[free_addr_reg] <= 1'b0;
            end
            if (cmd.remove) begin
                used_reg[found_addr_reg]  <= 1'b0;
                ready_reg[found_addr_reg] <= 1'b0;
            end
            if (cmd.clear_rdy) begin
                ready_reg[found_addr_reg] <= 1'b0;
            end
            // The ready mark is set even when the ring has no room.
            if (cmd.notify && matched != '0 && !ready_reg[found_addr_reg]) begin
                ready_reg[found_addr_reg] <= 1'b1;
                if (push_ok) begin
                    tail_reg[cur_reg] <= tail_wrap;
                end
            end
            if (cmd.emit_pop) begin
                head_reg[req_idx] <= head_wrap;
                pop_cnt_reg       <= pop_cnt_reg + 1'b1;
            end
            if (cmd.emit || cmd.emit_pop) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {4'd0, out_data_reg, out_ev_reg, out_idx_reg};

    always_comb begin
        stat             = '0;
        stat.kind        = kind_reg;
        stat.req_ok      = req_ok;
        stat.any_free    = any_free;
        stat.batch_ok    = (maxev_reg != 8'd0) && (int'(maxev_reg) <= MAX_BATCH);
        stat.ring_empty  = (head_req == tail_req);
        stat.hit         = hit;
        stat.scan_last   = (slot_reg == SW'(SLOTS - 1));
        stat.found       = found_reg;
        stat.free_found  = free_reg;
        stat.inst_active = active_reg[cur_reg];
        stat.inst_last   = (cur_reg == IW'(INSTANCES - 1));
        stat.out_free    = !out_valid_reg || m_tready;
        stat.pop_last    = pop_last;
    end

endmodule
`default_nettype wire

// ===== hdl/event_interest_table_ready_queue.sv =====
// Event notification engine with per-instance interest tables and ready rings.
// Commands enter on the s_ channel: s_tuser carries the command kind and
// s_tdata the operands. Each command answers on the m_ channel with one item,
// or for a wait with one item per popped event; m_tlast marks the final item
// and m_tuser carries the status (ok, error, nothing ready).
// One command is handled at a time; s_tready is high only while idle.
// Create, close, commands rejected at dispatch and an empty wait go from the
// dispatch state straight to the response state. Add, modify and delete walk
// the instance table slot by slot, through a read state and a check state on
// the slot memory read port, until the fd is found or the last slot is read.
// Notify and clear ready repeat that walk for each active instance. A wait
// alternates a ring memory read state and an emit state for each event it
// pops, until the batch limit is reached or the ring is empty.
// The user must write the edge flag mask (cfg_wr_en/cfg_wr_data) only while
// idle; the block does not enforce this. After reset all instances are closed
// and the mask is 0x80000000; no clearing pass is needed. A stalled receiver
// holds the result item in the output register; the next item waits.
`default_nettype none
`include "event_interest_table_ready_queue_macros.svh"
module event_interest_table_ready_queue
    import eitrq_pkg::*;
#(
    parameter int INSTANCES  = 4,
    parameter int SLOTS      = 16,
    parameter int RING_DEPTH = 16,
    parameter int MAX_BATCH  = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [31:0]       cfg_wr_data,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // instance_req, fd, interest_events, user_data, event_bits, max_events
    input  wire logic [IN_W-1:0]   s_tdata,
    // kind
    input  wire logic [2:0]        s_tuser,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // instance_index, ready_events, ready_data
    output logic [OUT_W-1:0]       m_tdata,
    // status
    output logic [1:0]             m_tuser,
    output logic                   m_tlast
);

    cmd_t  cmd;
    stat_t stat;

    // The controller sequences table walks, instance loops and wait batches.
    eitrq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the tables, rings and the output register.
    eitrq_dp #(
        .INSTANCES  (INSTANCES),
        .SLOTS      (SLOTS),
        .RING_DEPTH (RING_DEPTH),
        .MAX_BATCH  (MAX_BATCH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cmd         (cmd),
        .stat        (stat)
    );

    // A command in progress blocks the next one.
    `EITRQ_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // A result that is not final belongs to a wait still in progress.
    `EITRQ_ASSERT_NOW(a_partial_blocks_input, aclk, aresetn, m_tvalid && !m_tlast, !s_tready)
    // An empty wait is a single final item with no payload.
    `EITRQ_ASSERT_NOW(a_empty_is_final, aclk, aresetn, m_tvalid && m_tuser == ST_EMPTY, m_tlast && m_tdata == '0)

endmodule
`default_nettype wire
